// ===== sv/bcp_pkg.sv =====
//------------------------------------------------------------------------------
// bcp_pkg
// Shared types and constants for the bytecode container parser.
//------------------------------------------------------------------------------
package bcp_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
	localparam logic [7:0]  ID_CONST = 8'h01;
	localparam logic [7:0]  ID_VARS  = 8'h02;
	localparam logic [7:0]  ID_INSTR = 8'h03;
	localparam logic [7:0]  ID_FUNCS = 8'h04;

	// constant tags
	localparam logic [7:0]  TAG_NULL  = 8'h00;
	localparam logic [7:0]  TAG_BOOL  = 8'h01;
	localparam logic [7:0]  TAG_INT   = 8'h02;
	localparam logic [7:0]  TAG_FLOAT = 8'h03;
	localparam logic [7:0]  TAG_STR   = 8'h04;

	// record kinds
	localparam logic [3:0] RK_NULL   = 4'd0;
	localparam logic [3:0] RK_BOOL   = 4'd1;
	localparam logic [3:0] RK_INT    = 4'd2;
	localparam logic [3:0] RK_FLOAT  = 4'd3;
	localparam logic [3:0] RK_NLEN   = 4'd4;
	localparam logic [3:0] RK_NBYTE  = 4'd5;
	localparam logic [3:0] RK_VNEXT  = 4'd6;
	localparam logic [3:0] RK_VINDEX = 4'd7;
	localparam logic [3:0] RK_FADDR  = 4'd8;
	localparam logic [3:0] RK_INSTR  = 4'd9;
	localparam logic [3:0] RK_COUNT  = 4'd10;
	localparam logic [3:0] RK_STATUS = 4'd11;

	// sections
	localparam logic [2:0] SEC_HDR   = 3'd0;
	localparam logic [2:0] SEC_CONST = 3'd1;
	localparam logic [2:0] SEC_VARS  = 3'd2;
	localparam logic [2:0] SEC_INSTR = 3'd3;
	localparam logic [2:0] SEC_FUNCS = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_MAG  = 3'd1;
	localparam logic [2:0] ST_BAD_VER  = 3'd2;
	localparam logic [2:0] ST_CRC      = 3'd3;
	localparam logic [2:0] ST_BAD_SEC  = 3'd4;
	localparam logic [2:0] ST_BAD_TAG  = 3'd5;
	localparam logic [2:0] ST_TRUNC    = 3'd6;

	// config register indexes
	localparam logic [0:0] REG_MAGIC = 1'b0;
	localparam logic [0:0] REG_VER   = 1'b1;

	typedef enum logic [4:0] {
		P_MAGIC, P_VER, P_FLAGS, P_HCRC,
		P_C_ID, P_C_COUNT, P_C_TAG, P_C_BOOL, P_C_INT, P_C_FLOAT, P_C_SLEN, P_C_SBYTES,
		P_V_ID, P_V_COUNT, P_V_NEXT, P_V_SLEN, P_V_SBYTES, P_V_INDEX,
		P_F_ID, P_F_COUNT, P_F_SLEN, P_F_SBYTES, P_F_ADDR,
		P_I_ID, P_I_COUNT, P_I_OP, P_I_A, P_I_B, P_I_C,
		P_DONE, P_DRAIN
	} phase_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [2:0]  sec;
		logic [31:0] entry;
		logic [63:0] value;
		logic [7:0]  opcode;
		logic [31:0] opa;
		logic [31:0] opb;
		logic [31:0] opc;
		logic [2:0]  status;
		logic        last;
	} rec_t;

	// one byte of reflected CRC-32
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

// ===== sv/bytecode_container_parser_core.sv =====
//------------------------------------------------------------------------------
// bytecode_container_parser_core
// Byte-at-a-time parser of a bytecode container with header check and CRC-32.
//------------------------------------------------------------------------------
// Each record is registered in the output queue before the master side sees it.
// Throughput: one byte per cycle while the queue has room; a byte makes at most
// two records, and the second fills the two-entry queue, holding the slave side.
// Reset: arst_n clears parse state, the queue and both config registers.
// After each status record the parse state returns to its reset value.
module bytecode_container_parser_core import bcp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// APB config
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// byte stream in
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // end_of_buffer
	// record stream out
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [207:0] m_tdata,   // section[2:0] entry_number[34:3] value[98:35]
	                                // opcode[106:99] operand_a[138:107]
	                                // operand_b[170:139] operand_c[202:171]
	                                // status[205:203] zero pad[207:206]
	output logic [3:0]   m_tuser,   // record_kind[3:0]
	output logic         m_tlast    // last
);

	logic [31:0] magic_q, ver_q;
	phase_t      phase_q;
	logic [2:0]  fbc_q;
	logic [63:0] shift_q;
	logic [31:0] left_q, ecnt_q;
	logic [15:0] nleft_q;
	logic [31:0] crc_q, scrc_q;
	logic [2:0]  err_q;
	logic [7:0]  hop_q;
	logic [31:0] ha_q, hb_q;

	// config port
	assign pready = 1'b1;
	always_comb begin
		prdata = (paddr[2] == REG_VER) ? ver_q : magic_q;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0;
			ver_q   <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_MAGIC) magic_q <= pwdata;
			else ver_q <= pwdata;
		end
	end

	// output queue: two entries
	rec_t        q0_q, q1_q;
	logic [1:0]  qn_q;
	logic        acc, pop;
	assign s_tready = (qn_q == 2'd0) || (qn_q == 2'd1 && m_tready);
	assign acc = s_tvalid && s_tready;
	assign m_tvalid = qn_q != 2'd0;
	assign pop = m_tvalid && m_tready;
	assign m_tdata = {2'd0, q0_q.status, q0_q.opc, q0_q.opb, q0_q.opa, q0_q.opcode,
		q0_q.value, q0_q.entry, q0_q.sec};
	assign m_tuser = q0_q.kind;
	assign m_tlast = q0_q.last;

	// next-state of parser
	logic [7:0]  b;
	logic [63:0] asm_v;
	logic [2:0]  fbc_inc;
	phase_t      ph_n;
	logic [2:0]  fbc_n;
	logic [63:0] shift_n;
	logic [31:0] left_n, ecnt_n, crc_n, scrc_n, ha_n, hb_n;
	logic [15:0] nleft_n;
	logic [2:0]  err_n, st;
	logic [7:0]  hop_n;
	logic [3:0]  need;
	logic        full, e0, e1, fin;
	logic [3:0]  k0;
	logic [2:0]  sc0;
	logic [31:0] en0;
	logic [63:0] v0;
	logic        ins0;
	phase_t      fin_ent, fin_next;

	always_comb begin
		b = s_tdata;
		asm_v = shift_q | ({56'd0, b} << {fbc_q, 3'b000});
		fbc_inc = fbc_q + 3'd1;
		unique case (phase_q)
			P_C_INT, P_C_FLOAT: need = 4'd8;
			P_C_SLEN, P_V_SLEN, P_F_SLEN: need = 4'd2;
			default: need = 4'd4;
		endcase
		full = ({1'b0, fbc_inc} == need) || (need == 4'd8 && fbc_q == 3'd7);
		ph_n = phase_q; fbc_n = fbc_q; shift_n = shift_q; left_n = left_q;
		ecnt_n = ecnt_q; nleft_n = nleft_q; scrc_n = scrc_q; err_n = err_q;
		hop_n = hop_q; ha_n = ha_q; hb_n = hb_q;
		crc_n = (phase_q >= P_C_ID) ? crc_byte(crc_q, b) : crc_q;
		e0 = 1'b0; k0 = RK_NULL; sc0 = SEC_HDR; en0 = '0; v0 = '0; ins0 = 1'b0;
		fin = 1'b0; fin_ent = P_C_TAG; fin_next = P_V_ID;
		// field assembly for multi-byte phases
		if (phase_q == P_MAGIC || phase_q == P_VER || phase_q == P_FLAGS ||
		    phase_q == P_HCRC || phase_q == P_C_COUNT || phase_q == P_C_INT ||
		    phase_q == P_C_FLOAT || phase_q == P_C_SLEN || phase_q == P_V_COUNT ||
		    phase_q == P_V_NEXT || phase_q == P_V_SLEN || phase_q == P_V_INDEX ||
		    phase_q == P_F_COUNT || phase_q == P_F_SLEN || phase_q == P_F_ADDR ||
		    phase_q == P_I_COUNT || phase_q == P_I_A || phase_q == P_I_B ||
		    phase_q == P_I_C) begin
			if (full) begin
				shift_n = '0; fbc_n = '0;
			end else begin
				shift_n = asm_v; fbc_n = fbc_inc;
			end
		end
		unique case (phase_q)
			P_MAGIC: if (full) begin
				if (asm_v[31:0] != magic_q) begin err_n = ST_BAD_MAG; ph_n = P_DRAIN; end
				else ph_n = P_VER;
			end
			P_VER: if (full) begin
				if (asm_v[31:0] != ver_q) begin err_n = ST_BAD_VER; ph_n = P_DRAIN; end
				else ph_n = P_FLAGS;
			end
			P_FLAGS: if (full) ph_n = P_HCRC;
			P_HCRC: if (full) begin scrc_n = asm_v[31:0]; ph_n = P_C_ID; end
			P_C_ID: if (b == ID_CONST) ph_n = P_C_COUNT;
				else begin err_n = ST_BAD_SEC; ph_n = P_DRAIN; end
			P_C_COUNT: if (full) begin
				e0 = 1'b1; k0 = RK_COUNT; sc0 = SEC_CONST; v0 = asm_v;
				left_n = asm_v[31:0]; ecnt_n = '0;
				ph_n = (asm_v[31:0] != 0) ? P_C_TAG : P_V_ID;
			end
			P_C_TAG: unique case (b)
				TAG_NULL: begin
					e0 = 1'b1; k0 = RK_NULL; sc0 = SEC_CONST; en0 = ecnt_q; fin = 1'b1;
				end
				TAG_BOOL: ph_n = P_C_BOOL;
				TAG_INT: ph_n = P_C_INT;
				TAG_FLOAT: ph_n = P_C_FLOAT;
				TAG_STR: ph_n = P_C_SLEN;
				default: begin err_n = ST_BAD_TAG; ph_n = P_DRAIN; end
			endcase
			P_C_BOOL: begin
				e0 = 1'b1; k0 = RK_BOOL; sc0 = SEC_CONST; en0 = ecnt_q;
				v0 = {63'd0, b != 8'd0}; fin = 1'b1;
			end
			P_C_INT, P_C_FLOAT: if (full) begin
				e0 = 1'b1; k0 = (phase_q == P_C_INT) ? RK_INT : RK_FLOAT; sc0 = SEC_CONST;
				en0 = ecnt_q; v0 = asm_v; fin = 1'b1;
			end
			P_C_SLEN: if (full) begin
				e0 = 1'b1; k0 = RK_NLEN; sc0 = SEC_CONST; en0 = ecnt_q; v0 = {48'd0, asm_v[15:0]};
				nleft_n = asm_v[15:0];
				if (asm_v[15:0] != 0) ph_n = P_C_SBYTES; else fin = 1'b1;
			end
			P_C_SBYTES: begin
				e0 = 1'b1; k0 = RK_NBYTE; sc0 = SEC_CONST; en0 = ecnt_q; v0 = {56'd0, b};
				nleft_n = nleft_q - 16'd1;
				if (nleft_q == 16'd1) fin = 1'b1;
			end
			P_V_ID: if (b == ID_VARS) ph_n = P_V_COUNT;
				else begin err_n = ST_BAD_SEC; ph_n = P_DRAIN; end
			P_V_COUNT: if (full) begin
				e0 = 1'b1; k0 = RK_COUNT; sc0 = SEC_VARS; v0 = asm_v;
				left_n = asm_v[31:0]; ecnt_n = '0; ph_n = P_V_NEXT;
			end
			P_V_NEXT: if (full) begin
				e0 = 1'b1; k0 = RK_VNEXT; sc0 = SEC_VARS; v0 = asm_v;
				ph_n = (left_q != 0) ? P_V_SLEN : P_F_ID;
			end
			P_V_SLEN, P_F_SLEN: if (full) begin
				e0 = 1'b1; k0 = RK_NLEN; sc0 = (phase_q == P_V_SLEN) ? SEC_VARS : SEC_FUNCS;
				en0 = ecnt_q; v0 = {48'd0, asm_v[15:0]}; nleft_n = asm_v[15:0];
				if (phase_q == P_V_SLEN) ph_n = (asm_v[15:0] != 0) ? P_V_SBYTES : P_V_INDEX;
				else ph_n = (asm_v[15:0] != 0) ? P_F_SBYTES : P_F_ADDR;
			end
			P_V_SBYTES, P_F_SBYTES: begin
				e0 = 1'b1; k0 = RK_NBYTE; sc0 = (phase_q == P_V_SBYTES) ? SEC_VARS : SEC_FUNCS;
				en0 = ecnt_q; v0 = {56'd0, b}; nleft_n = nleft_q - 16'd1;
				if (nleft_q == 16'd1) ph_n = (phase_q == P_V_SBYTES) ? P_V_INDEX : P_F_ADDR;
			end
			P_V_INDEX: if (full) begin
				e0 = 1'b1; k0 = RK_VINDEX; sc0 = SEC_VARS; en0 = ecnt_q; v0 = asm_v;
				fin = 1'b1; fin_ent = P_V_SLEN; fin_next = P_F_ID;
			end
			P_F_ID: if (b == ID_FUNCS) ph_n = P_F_COUNT;
				else begin err_n = ST_BAD_SEC; ph_n = P_DRAIN; end
			P_F_COUNT: if (full) begin
				e0 = 1'b1; k0 = RK_COUNT; sc0 = SEC_FUNCS; v0 = asm_v;
				left_n = asm_v[31:0]; ecnt_n = '0;
				ph_n = (asm_v[31:0] != 0) ? P_F_SLEN : P_I_ID;
			end
			P_F_ADDR: if (full) begin
				e0 = 1'b1; k0 = RK_FADDR; sc0 = SEC_FUNCS; en0 = ecnt_q; v0 = asm_v;
				fin = 1'b1; fin_ent = P_F_SLEN; fin_next = P_I_ID;
			end
			P_I_ID: if (b == ID_INSTR) ph_n = P_I_COUNT;
				else begin err_n = ST_BAD_SEC; ph_n = P_DRAIN; end
			P_I_COUNT: if (full) begin
				e0 = 1'b1; k0 = RK_COUNT; sc0 = SEC_INSTR; v0 = asm_v;
				left_n = asm_v[31:0]; ecnt_n = '0;
				ph_n = (asm_v[31:0] != 0) ? P_I_OP : P_DONE;
			end
			P_I_OP: begin hop_n = b; ph_n = P_I_A; end
			P_I_A: if (full) begin ha_n = asm_v[31:0]; ph_n = P_I_B; end
			P_I_B: if (full) begin hb_n = asm_v[31:0]; ph_n = P_I_C; end
			P_I_C: if (full) begin
				e0 = 1'b1; k0 = RK_INSTR; sc0 = SEC_INSTR; en0 = ecnt_q; ins0 = 1'b1;
				fin = 1'b1; fin_ent = P_I_OP; fin_next = P_DONE;
			end
			default: ;
		endcase
		if (fin) begin
			ecnt_n = ecnt_q + 32'd1;
			left_n = left_q - 32'd1;
			ph_n = (left_q != 32'd1) ? fin_ent : fin_next;
		end
		// final status on the end mark
		e1 = s_tlast;
		if (err_n == ST_BAD_MAG || err_n == ST_BAD_VER) st = err_n;
		else if (ph_n < P_C_ID) st = ST_TRUNC;
		else if ((crc_n ^ CRC_ONES) != scrc_n) st = ST_CRC;
		else if (err_n != ST_OK) st = err_n;
		else if (ph_n != P_DONE) st = ST_TRUNC;
		else st = ST_OK;
	end

	rec_t r0, r1;
	always_comb begin
		r0 = '0;
		r0.kind = k0; r0.sec = sc0; r0.entry = en0; r0.value = v0;
		if (ins0) begin
			r0.opcode = hop_q; r0.opa = ha_q; r0.opb = hb_q; r0.opc = asm_v[31:0];
		end
		r1 = '0;
		r1.kind = RK_STATUS; r1.status = st; r1.last = 1'b1;
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_MAGIC; fbc_q <= '0; shift_q <= '0; left_q <= '0; ecnt_q <= '0;
			nleft_q <= '0; crc_q <= CRC_ONES; scrc_q <= '0; err_q <= ST_OK;
			hop_q <= '0; ha_q <= '0; hb_q <= '0;
		end else if (acc) begin
			if (s_tlast) begin
				phase_q <= P_MAGIC; fbc_q <= '0; shift_q <= '0; left_q <= '0; ecnt_q <= '0;
				nleft_q <= '0; crc_q <= CRC_ONES; scrc_q <= '0; err_q <= ST_OK;
				hop_q <= '0; ha_q <= '0; hb_q <= '0;
			end else begin
				phase_q <= ph_n; fbc_q <= fbc_n; shift_q <= shift_n; left_q <= left_n;
				ecnt_q <= ecnt_n; nleft_q <= nleft_n; crc_q <= crc_n; scrc_q <= scrc_n;
				err_q <= err_n; hop_q <= hop_n; ha_q <= ha_n; hb_q <= hb_n;
			end
		end
	end

	// output queue update: pop then push up to two records
	logic [1:0] np, base;
	rec_t       a0, a1, q0_n, q1_n;
	always_comb begin
		np = acc ? ({1'b0, e0} + {1'b0, e1}) : 2'd0;
		a0 = e0 ? r0 : r1;
		a1 = r1;
		base = qn_q - {1'b0, pop};
		q0_n = pop ? q1_q : q0_q;
		q1_n = q1_q;
		if (np != 2'd0) begin
			if (base == 2'd0) begin
				q0_n = a0;
				if (np == 2'd2) q1_n = a1;
			end else begin
				q1_n = a0;
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) qn_q <= '0;
		else qn_q <= base + np;
	end
	always_ff @(posedge clk) begin
		q0_q <= q0_n;
		q1_q <= q1_n;
	end

	// checks
	a_qmax: assert property (@(posedge clk) disable iff (!arst_n) qn_q <= 2'd2)
		else $error("queue overflow");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(qn_q == 2'd2) |-> !s_tready) else $error("ready while queue full");
	a_reset_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tlast) |=> (phase_q == P_MAGIC)) else $error("no restart after end");
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (q0_q.kind == RK_STATUS)) else $error("last on non-status");

endmodule
